>>> hw/rtl/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg: shared types and helpers of the ftp reply parser
// constants, status codes, result struct and reply code decoding
// ----------------------------------------------------------------------------
package frp_pkg;

    localparam int LINE_LIMIT_DEF = 512;
    localparam int CAP_W          = 16;
    localparam int CODE_W         = 10;
    localparam int HEAD_N         = 4;

    localparam logic [CAP_W-1:0] CAPACITY_RST = 16'd4096;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_PROTO_ERR = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [CODE_W-1:0] reply_code;
        status_t           status;
    } result_t;

    function automatic logic is_dec(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    // digits are ascii, so the low nibble is the digit value
    function automatic logic [CODE_W-1:0] head_value(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2
    );
        logic [CODE_W-1:0] v;
        v = CODE_W'(b0[3:0]) * CODE_W'(100)
          + CODE_W'(b1[3:0]) * CODE_W'(10)
          + CODE_W'(b2[3:0]);
        return v;
    endfunction

endpackage

>>> hw/rtl/frp_core.sv
// ----------------------------------------------------------------------------
// frp_core: reply framing state of the ftp reply parser
// tracks line head, line and text length and gives one result per reply
// ----------------------------------------------------------------------------
module frp_core
    import frp_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic             in_closed,
    input  logic [CAP_W-1:0] reply_capacity,
    output logic             res_valid,
    output result_t          res
);

    localparam int LEN_W = $clog2(LINE_LIMIT);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_LIMIT - 1);

    logic [LEN_W-1:0]  line_len_reg, line_len_next;
    logic [CAP_W-1:0]  text_len_reg, text_len_next;
    logic [7:0]        head_reg [HEAD_N];
    logic [7:0]        head_next [HEAD_N];
    logic              first_line_reg, first_line_next;
    logic              multi_reg, multi_next;
    logic [CODE_W-1:0] exp_code_reg, exp_code_next;

    logic              stores;
    logic [LEN_W-1:0]  len_new;
    logic [7:0]        head_new [HEAD_N];
    logic [CAP_W:0]    text_sum;
    logic              over;
    logic              digits_ok;
    logic [CODE_W-1:0] code_new;
    logic              restart;
    logic              clear_line;

    assign stores = (line_len_reg != LEN_MAX);
    assign len_new = stores ? line_len_reg + LEN_W'(1) : line_len_reg;

    always_comb
    begin
        for (int i = 0; i < HEAD_N; i++)
        begin
            head_new[i] = (stores && line_len_reg == LEN_W'(i)) ? in_byte : head_reg[i];
        end
    end

    assign text_sum  = {1'b0, text_len_reg} + (CAP_W + 1)'(len_new);
    assign over      = (text_sum >= {1'b0, reply_capacity});
    assign digits_ok = is_dec(head_new[0]) && is_dec(head_new[1]) && is_dec(head_new[2]);
    assign code_new  = head_value(head_new[0], head_new[1], head_new[2]);

    always_comb
    begin
        res_valid       = 1'b0;
        res.reply_code  = '0;
        res.status      = ST_OK;
        restart         = 1'b0;
        clear_line      = 1'b0;
        line_len_next   = line_len_reg;
        text_len_next   = text_len_reg;
        first_line_next = first_line_reg;
        multi_next      = multi_reg;
        exp_code_next   = exp_code_reg;
        for (int i = 0; i < HEAD_N; i++)
        begin
            head_next[i] = head_reg[i];
        end

        if (in_valid)
        begin
            if (in_closed)
            begin
                res_valid  = 1'b1;
                res.status = ST_PROTO_ERR;
                restart    = 1'b1;
            end
            else if (in_byte != CH_LF)
            begin
                line_len_next = len_new;
                for (int i = 0; i < HEAD_N; i++)
                begin
                    head_next[i] = head_new[i];
                end
            end
            // the capacity test comes before any head check
            else if (over)
            begin
                res_valid  = 1'b1;
                res.status = ST_OVERFLOW;
                restart    = 1'b1;
            end
            else if (first_line_reg)
            begin
                if (!digits_ok)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_PROTO_ERR;
                    restart    = 1'b1;
                end
                else if (head_new[3] == CH_HYPHEN)
                begin
                    multi_next      = 1'b1;
                    first_line_next = 1'b0;
                    exp_code_next   = code_new;
                    text_len_next   = text_sum[CAP_W-1:0];
                    clear_line      = 1'b1;
                end
                else if (head_new[3] == CH_SPACE)
                begin
                    res_valid      = 1'b1;
                    res.reply_code = code_new;
                    restart        = 1'b1;
                end
                else
                begin
                    res_valid  = 1'b1;
                    res.status = ST_PROTO_ERR;
                    restart    = 1'b1;
                end
            end
            else if (multi_reg && digits_ok && code_new == exp_code_reg
                     && head_new[3] == CH_SPACE)
            begin
                res_valid      = 1'b1;
                res.reply_code = exp_code_reg;
                restart        = 1'b1;
            end
            else
            begin
                // continuation line inside a multi-line reply
                text_len_next = text_sum[CAP_W-1:0];
                clear_line    = 1'b1;
            end

            if (clear_line)
            begin
                line_len_next = '0;
                for (int i = 0; i < HEAD_N; i++)
                begin
                    head_next[i] = '0;
                end
            end

            if (restart)
            begin
                line_len_next   = '0;
                text_len_next   = '0;
                first_line_next = 1'b1;
                multi_next      = 1'b0;
                exp_code_next   = '0;
                for (int i = 0; i < HEAD_N; i++)
                begin
                    head_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg   <= '0;
            text_len_reg   <= '0;
            first_line_reg <= 1'b1;
            multi_reg      <= 1'b0;
            exp_code_reg   <= '0;
            for (int i = 0; i < HEAD_N; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            line_len_reg   <= line_len_next;
            text_len_reg   <= text_len_next;
            first_line_reg <= first_line_next;
            multi_reg      <= multi_next;
            exp_code_reg   <= exp_code_next;
            for (int i = 0; i < HEAD_N; i++)
            begin
                head_reg[i] <= head_next[i];
            end
        end
    end

endmodule

>>> hw/rtl/ftp_reply_parser.sv
// ----------------------------------------------------------------------------
// ftp_reply_parser: ftp control channel reply end detector
// one received word per cycle in, one result word per finished reply out
// ----------------------------------------------------------------------------
// result: the word that ends a reply is registered into the result queue, whose head drives m_axis
// throughput: one word per cycle; the two-entry result queue stalls s_axis
//   only while two result words wait for the sink
// reset: parser state cleared to the start of a reply, result queue empty,
//   reply capacity 4096
// ----------------------------------------------------------------------------
module ftp_reply_parser
    import frp_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
    input  logic             s_axis_tuser,   // [0] link_closed
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [9:0] reply_code, [15:10] zero
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    logic [CAP_W-1:0] capacity_reg;
    logic             in_valid;
    logic             res_valid;
    result_t          res;

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RST;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign in_valid      = s_axis_tvalid && s_axis_tready;

    frp_core #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_byte        (s_axis_tdata),
        .in_closed      (s_axis_tuser),
        .reply_capacity (capacity_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // slot0 drives the output, slot1 holds a result behind it
    assign pop = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (cnt_reg)
            2'd0:
            begin
                if (res_valid)
                begin
                    slot0_next = res;
                    cnt_next   = 2'd1;
                end
            end
            2'd1:
            begin
                if (res_valid && pop)
                begin
                    slot0_next = res;
                end
                else if (res_valid)
                begin
                    slot1_next = res;
                    cnt_next   = 2'd2;
                end
                else if (pop)
                begin
                    cnt_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    cnt_next   = 2'd1;
                end
            end
            default:
            begin
                cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {(16 - CODE_W)'(0), slot0_reg.reply_code};
    assign m_axis_tuser  = slot0_reg.status;

endmodule

>>> verif/tb_ftp_reply_parser.sv
// ----------------------------------------------------------------------------
// tb_ftp_reply_parser: self-checking bench of the ftp reply end detector
// feeds reply byte streams (directed corner cases, then random replies under
// several capacities), predicts each result word and compares it field by field
// ----------------------------------------------------------------------------
module tb_ftp_reply_parser;
    import frp_pkg::*;

    localparam int LINE_MAX    = LINE_LIMIT_DEF;
    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int CAP_BYTES   = 10;

    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum int
    {
        SINK_OPEN,
        SINK_MOSTLY,
        SINK_SPARSE,
        SINK_TOGGLE
    } sink_mode_e;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_we        = 1'b0;
    logic [CAP_W-1:0] cfg_wdata     = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [15:0]      m_axis_tdata;
    logic [1:0]       m_axis_tuser;

    ftp_reply_parser #(
        .LINE_LIMIT (LINE_MAX)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // parser mirror
    int unsigned       cap_bytes  = CAPACITY_RST;
    int unsigned       line_bytes = 0;
    int unsigned       text_bytes = 0;
    logic [7:0]        head [HEAD_N] = '{default: '0};
    bit                first_line = 1'b1;
    bit                multi_line = 1'b0;
    logic [CODE_W-1:0] open_code  = '0;

    result_t    replies_due[$];
    logic [7:0] line_buf[$];
    int         errors       = 0;
    int         bytes_sent   = 0;
    int         burst_left   = 1;
    bit         src_offering = 1'b0;
    bit         hold_req     = 1'b0;

    function void clear_reply();
        line_bytes = 0;
        text_bytes = 0;
        foreach (head[i])
            head[i] = '0;
        first_line = 1'b1;
        multi_line = 1'b0;
        open_code  = '0;
    endfunction

    function bit head_has_code();
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < 3; i++)
            ok &= (head[i] >= CH_ZERO) && (head[i] <= CH_ZERO + 8'd9);
        return ok;
    endfunction

    function logic [CODE_W-1:0] head_code();
        return CODE_W'(head[0] - CH_ZERO) * CODE_W'(100)
             + CODE_W'(head[1] - CH_ZERO) * CODE_W'(10)
             + CODE_W'(head[2] - CH_ZERO);
    endfunction

    // returns 1 when the byte finishes a reply; res then holds the result word
    function bit predict_byte(input logic [7:0] b, input logic closed, output result_t res);
        res.reply_code = '0;
        res.status     = ST_OK;
        if (closed)
        begin
            res.status = ST_PROTO_ERR;
            clear_reply();
            return 1'b1;
        end
        // saturated line: bytes dropped, a line feed still ends the line
        if (line_bytes < LINE_MAX - 1)
        begin
            if (line_bytes < HEAD_N)
                head[line_bytes] = b;
            line_bytes++;
        end
        if (b != CH_LF)
            return 1'b0;
        // capacity is tested before the head of the line
        if (text_bytes + line_bytes >= cap_bytes)
        begin
            res.status = ST_OVERFLOW;
            clear_reply();
            return 1'b1;
        end
        text_bytes += line_bytes;
        if (first_line)
        begin
            if (!head_has_code())
            begin
                res.status = ST_PROTO_ERR;
                clear_reply();
                return 1'b1;
            end
            open_code  = head_code();
            first_line = 1'b0;
            if (head[3] == CH_HYPHEN)
                multi_line = 1'b1;
            else if (head[3] == CH_SPACE)
            begin
                res.reply_code = open_code;
                clear_reply();
                return 1'b1;
            end
            else
            begin
                res.status = ST_PROTO_ERR;
                clear_reply();
                return 1'b1;
            end
        end
        else if (multi_line && head_has_code() && head_code() == open_code
                 && head[3] == CH_SPACE)
        begin
            res.reply_code = open_code;
            clear_reply();
            return 1'b1;
        end
        line_bytes = 0;
        foreach (head[i])
            head[i] = '0;
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result word with nothing expected: reply_code %0d status %0d",
                       m_axis_tdata[CODE_W-1:0], m_axis_tuser);
                errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (m_axis_tdata[CODE_W-1:0] !== want.reply_code)
                begin
                    $error("reply_code: expected %0d, got %0d",
                           want.reply_code, m_axis_tdata[CODE_W-1:0]);
                    errors++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[15:CODE_W] !== '0)
                begin
                    $error("tdata_pad: expected 0, got %0d", m_axis_tdata[15:CODE_W]);
                    errors++;
                end
            end
        end
    end

    // result sink: random ready pattern, plus a long hold-off on request
    initial
    begin
        sink_mode_e mode;
        int         mode_left;
        int         hold_left;
        bit         rdy;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        rdy       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rdy       = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   rdy = 1'b1;
                    SINK_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
                    SINK_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:     rdy = ~rdy;
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        $error("no word moved for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, replies_due.size());
        $display("** ftp_reply_parser: FAILED **");
        $finish;
    end

    task src_idle(input int n);
        if (src_offering)
        begin
            s_axis_tvalid <= 1'b0;
            src_offering = 1'b0;
        end
        repeat (n) @(posedge clk);
    endtask

    task send_byte(input logic [7:0] b, input logic closed);
        result_t res;
        s_axis_tdata  <= b;
        s_axis_tuser  <= closed;
        s_axis_tvalid <= 1'b1;
        src_offering = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        if (predict_byte(b, closed, res))
            replies_due.push_back(res);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
            src_idle($urandom_range(1, 12));
        end
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task wait_replies(input int extra);
        src_idle(0);
        do @(posedge clk); while (replies_due.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task set_capacity(input logic [CAP_W-1:0] v);
        wait_replies(3);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_bytes = v;
        @(posedge clk);
    endtask

    function logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= CH_LF)
            b++;
        return b;
    endfunction

    function logic [7:0] non_digit();
        logic [7:0] b;
        b = 8'($urandom_range(0, 245));
        if (b >= CH_ZERO)
            b += 10;
        return b;
    endfunction

    function int text_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
    endfunction

    task push_head(input int code, input logic [7:0] mark);
        line_buf.push_back(CH_ZERO + 8'(code / 100));
        line_buf.push_back(CH_ZERO + 8'((code / 10) % 10));
        line_buf.push_back(CH_ZERO + 8'(code % 10));
        line_buf.push_back(mark);
    endtask

    task push_tail(input int n);
        repeat (n) line_buf.push_back(text_byte());
        line_buf.push_back(CH_LF);
    endtask

    task send_random_reply();
        int         kind;
        int         code;
        int         pos;
        int         abort_at;
        logic [7:0] mark;
        kind = $urandom_range(0, 99);
        code = $urandom_range(0, 999);
        if (kind < 8)
        begin
            // noise, line feeds included
            repeat ($urandom_range(1, 8))
                line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom));
        end
        else if (kind < 12)
        begin
            // line that ends before the head is complete
            repeat ($urandom_range(0, 3))
                line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            line_buf.push_back(CH_LF);
        end
        else if (kind < 18)
        begin
            push_head(code, CH_SPACE);
            pos = $urandom_range(0, 3);
            if (pos < 3)
                line_buf[pos] = non_digit();
            else
            begin
                mark = 8'($urandom_range(0, 253));
                if (mark >= CH_SPACE)
                    mark++;
                if (mark >= CH_HYPHEN)
                    mark++;
                line_buf[3] = mark;
            end
            push_tail(text_len());
        end
        else if (kind < 55)
        begin
            push_head(code, CH_SPACE);
            push_tail(text_len());
        end
        else
        begin
            push_head(code, CH_HYPHEN);
            push_tail(text_len());
            repeat ($urandom_range(0, 3))
            begin
                case ($urandom_range(0, 3))
                    0: push_tail(text_len());
                    1: push_head(code, CH_HYPHEN);
                    2: push_head((code + $urandom_range(1, 999)) % 1000, CH_SPACE);
                    default: push_head(code, non_digit());
                endcase
                if (line_buf[line_buf.size() - 1] != CH_LF)
                    push_tail(text_len());
            end
            push_head(code, CH_SPACE);
            push_tail(text_len());
        end
        abort_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, line_buf.size() - 1) : -1;
        foreach (line_buf[i])
        begin
            if (i == abort_at)
                send_byte(8'($urandom), 1'b1);
            send_byte(line_buf[i], 1'b0);
        end
        line_buf.delete();
    endtask

    task test_reply_codes();
        send_text("000 ok\n");
        send_text("999 \n");
        // lines of other shapes inside a multi-line reply are skipped
        send_text("123-a\n12 x\n124 b\n123-c\n123 end\n");
    endtask

    task test_bad_heads();
        send_text("\n");
        send_text("12\n");
        send_text("123\n");
        send_text("1a3 \n");
        send_text("123x\n");
    endtask

    task test_link_closed();
        send_text("250-");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_text("250 \n");
    endtask

    // line runs past the limit, so the line feed is not stored, but it still ends the line
    task test_long_line();
        send_text("250 ");
        repeat (LINE_MAX - 2) send_byte(text_byte(), 1'b0);
        send_byte(CH_LF, 1'b0);
    endtask

    task test_capacity();
        set_capacity(16'd5);
        send_text("abcd\n");
        set_capacity(16'd10);
        send_text("200-abc\n200 \n");
        set_capacity(16'd0);
        send_text("\n");
        set_capacity(16'd1);
        send_text("7\n");
        set_capacity(16'd65535);
        send_text("421 x\n");
    endtask

    // sink holds off while link-closed words keep producing results
    task test_sink_hold();
        hold_req = 1'b1;
        repeat (12) send_byte(8'($urandom), 1'b1);
        send_text("331 \n");
        wait_replies(2);
    endtask

    task test_random();
        int unsigned caps [6];
        int          start;
        caps = '{4096, 65535, 48, 1, 0, 600};
        foreach (caps[p])
        begin
            set_capacity(CAP_W'(caps[p]));
            start = bytes_sent;
            while (bytes_sent - start < CAP_BYTES)
                send_random_reply();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reply_codes();
        test_bad_heads();
        test_link_closed();
        test_long_line();
        test_capacity();
        test_sink_hold();
        test_random();
        wait_replies(4);
        if (errors == 0)
            $display("** ftp_reply_parser: PASSED **");
        else
            $display("** ftp_reply_parser: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/frp_pkg.sv
hw/rtl/frp_core.sv
hw/rtl/ftp_reply_parser.sv
verif/tb_ftp_reply_parser.sv
